[src/cbq_pkg.sv]
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types, constants and coefficient table for the cascaded biquad
// equaliser: fixed coefficients at 30 fraction bits, rounding and saturation helpers.
// ----------------------------------------------------------------------------
package cbq_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned STATE_W    = 48;
  localparam int unsigned ACC_W      = 52;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned OPND_W     = 48;
  localparam int unsigned HALF_W     = 24;
  localparam int unsigned MUL_W      = 56;
  localparam int unsigned PROD_W     = 80;
  localparam int unsigned MAG_W      = 49;
  localparam int unsigned TAB_FRAC   = 30;
  localparam int unsigned GAIN_SHIFT = 40;
  localparam int unsigned MAX_SECT   = 8;
  localparam int unsigned NUM_COEF   = 5;

  localparam logic [GAIN_W-1:0]          GAIN_RESET = 24'd8389;
  localparam logic signed [STATE_W-1:0]  ST_MAX     = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0]  ST_MIN     = {1'b1, {(STATE_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0]        SAMPLE_MAX = 16'h7fff;
  localparam logic [SAMPLE_W-1:0]        SAMPLE_MIN = 16'h8000;
  localparam logic [MAG_W-1:0]           MAG_LIM    = {1'b1, {(MAG_W-1){1'b0}}};

  typedef enum logic [2:0] {
    K_B0 = 3'd0,
    K_B1 = 3'd1,
    K_B2 = 3'd2,
    K_A1 = 3'd3,
    K_A2 = 3'd4
  } coef_e;

  typedef enum logic [2:0] {
    OP_B0   = 3'd0,
    OP_B1   = 3'd1,
    OP_A1   = 3'd2,
    OP_B2   = 3'd3,
    OP_A2   = 3'd4,
    OP_GAIN = 3'd5
  } op_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_MLO  = 7'b0000100,
    ST_MHI  = 7'b0001000,
    ST_SUM  = 7'b0010000,
    ST_ACC  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic gain;
  } mul_ctrl_t;

  typedef struct packed {
    logic signed [STATE_W-1:0] d0;
    logic signed [STATE_W-1:0] d1;
  } dly_t;

  // b0, b1, b2, a1, a2 per section
  localparam logic signed [COEF_W-1:0] COEF_Q30 [MAX_SECT][NUM_COEF] = '{
    '{32'sd1221514753, -32'sd1985847615, 32'sd837320252,
      -32'sd2018691940, 32'sd952248855},
    '{32'sd717532791, 32'sd411752849, 32'sd614927420,
      32'sd411752849, 32'sd258718387},
    '{32'sd773780800, 32'sd644023408, 32'sd0, 32'sd344062384, 32'sd0},
    '{32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0}
  };

  // coefficient rounded half away from zero to frac fraction bits
  function automatic logic signed [COEF_W-1:0] coef_val(logic [2:0] sec, coef_e k,
                                                      int unsigned frac);
    logic signed [COEF_W-1:0] v;
    logic [COEF_W-1:0]        m;
    int unsigned              s;
    v = COEF_Q30[sec][k];
    s = TAB_FRAC - frac;
    m = v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
    if (s != 0) begin
      m = (m + (32'd1 << (s - 1))) >> s;
    end
    return v[COEF_W-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [STATE_W-1:0] sat48(logic signed [ACC_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if (v[ACC_W-1:STATE_W-1] == {(ACC_W-STATE_W+1){v[ACC_W-1]}}) begin
      r = v[STATE_W-1:0];
    end else begin
      r = v[ACC_W-1] ? ST_MIN : ST_MAX;
    end
    return r;
  endfunction

endpackage

[src/cbq_if.sv]
// ----------------------------------------------------------------------------
// cbq_if
// Valid/ready stream interfaces for the sample input and the result output.
// ----------------------------------------------------------------------------
interface cbq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface cbq_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic               clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

[src/cbq_mul.sv]
// ----------------------------------------------------------------------------
// cbq_mul
// Shared sign-magnitude multiplier: 32 x 24 bit product per cycle over two
// halves of the operand, rounding half away from zero and capping at 2^48.
// ----------------------------------------------------------------------------
module cbq_mul #(
  parameter int unsigned COEF_FRAC_BITS = 22
) (
  input  logic                clk_i,
  input  cbq_pkg::mul_ctrl_t  ctrl_i,
  input  logic [31:0]         mc_i,
  input  logic [47:0]         my_i,
  output logic [48:0]         mag_o
);
  import cbq_pkg::*;

  localparam logic [PROD_W-1:0] RND_C = PROD_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] RND_G = PROD_W'(1) << (GAIN_SHIFT - 1);

  logic [MUL_W-1:0]  mul_q;
  logic [PROD_W-1:0] prod_q;
  logic [HALF_W-1:0] opnd_half;
  logic [MUL_W-1:0]  mul_w;
  logic [PROD_W-1:0] shifted;

  assign opnd_half = ctrl_i.mul_hi ? my_i[OPND_W-1:HALF_W] : my_i[HALF_W-1:0];
  assign mul_w     = mc_i * opnd_half;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_lo || ctrl_i.mul_hi) begin
      mul_q <= mul_w;
    end
    if (ctrl_i.mul_hi) begin
      prod_q <= PROD_W'(mul_q) + (ctrl_i.gain ? RND_G : RND_C);
    end else if (ctrl_i.sum) begin
      prod_q <= prod_q + {mul_q, {HALF_W{1'b0}}};
    end
  end

  assign shifted = ctrl_i.gain ? (prod_q >> GAIN_SHIFT) : (prod_q >> COEF_FRAC_BITS);
  assign mag_o   = (|shifted[PROD_W-1:MAG_W-1]) ? MAG_LIM : {1'b0, shifted[MAG_W-2:0]};

endmodule

[src/cascaded_biquad_equalizer.sv]
// ----------------------------------------------------------------------------
// cascaded_biquad_equalizer
// Each product passes through the load, low-half multiply, high-half multiply,
// sum and accumulate states of the shared unit. A new input beat is taken only
// in idle, once the previous result has been loaded into the output register.
// Reset clears the section delays, sets the gain to its default, empties the
// output register.
// ----------------------------------------------------------------------------
module cascaded_biquad_equalizer #(
  parameter int unsigned SECTIONS       = 3,
  parameter int unsigned COEF_FRAC_BITS = 22
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  cbq_in_if.sink      in_i,
  cbq_out_if.source   out_o
);
  import cbq_pkg::*;

  localparam int unsigned SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  state_e                    state_q, state_d;
  op_e                       op_q, op_d;
  logic [SEC_W-1:0]          sec_q, sec_d;
  dly_t                      dly_q [SECTIONS];
  logic [GAIN_W-1:0]         gain_q;
  logic                      out_valid_q;
  logic [SAMPLE_W-1:0]       out_sample_q;
  logic                      out_clip_q;

  logic signed [STATE_W-1:0] y_q;
  logic signed [STATE_W-1:0] yn_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [COEF_W-1:0]         mc_q;
  logic [OPND_W-1:0]         my_q;
  logic                      neg_q;

  mul_ctrl_t                 mctrl;
  logic [MAG_W-1:0]          mag;
  logic                      in_acc;
  logic                      out_load;
  logic                      use_yn;
  logic                      is_sub;
  coef_e                     k_sel;
  logic signed [COEF_W-1:0]  cval;
  logic signed [STATE_W-1:0] opnd;
  logic signed [ACC_W-1:0]   acc_init;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   acc_new;
  logic signed [STATE_W-1:0] acc_sat;
  logic                      in_range;
  logic                      last_sec;

  assign in_i.ready      = (state_q == ST_IDLE);
  assign in_acc          = in_i.valid && in_i.ready;
  assign out_load        = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
  assign out_o.valid     = out_valid_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.clipped   = out_clip_q;

  assign use_yn   = (op_q == OP_A1) || (op_q == OP_A2);
  assign is_sub   = use_yn;
  assign last_sec = (sec_q == SEC_W'(SECTIONS - 1));
  assign opnd     = use_yn ? yn_q : y_q;

  always_comb begin
    case (op_q)
      OP_B0:   k_sel = K_B0;
      OP_B1:   k_sel = K_B1;
      OP_A1:   k_sel = K_A1;
      OP_B2:   k_sel = K_B2;
      OP_A2:   k_sel = K_A2;
      default: k_sel = K_B0;
    endcase
  end

  assign cval = coef_val(3'(sec_q), k_sel, COEF_FRAC_BITS);

  always_comb begin
    case (op_q)
      OP_B0:   acc_init = ACC_W'(dly_q[sec_q].d0);
      OP_B1:   acc_init = ACC_W'(dly_q[sec_q].d1);
      OP_A1:   acc_init = acc_q;
      OP_A2:   acc_init = acc_q;
      default: acc_init = '0;
    endcase
  end

  assign term     = $signed({{(ACC_W-MAG_W){1'b0}}, mag});
  assign acc_new  = (neg_q ^ is_sub) ? (acc_q - term) : (acc_q + term);
  assign acc_sat  = sat48(acc_new);
  assign in_range = (acc_q[ACC_W-1:SAMPLE_W-1] == {(ACC_W-SAMPLE_W+1){acc_q[ACC_W-1]}});

  assign mctrl.mul_lo = (state_q == ST_MLO);
  assign mctrl.mul_hi = (state_q == ST_MHI);
  assign mctrl.sum    = (state_q == ST_SUM);
  assign mctrl.gain   = (op_q == OP_GAIN);

  cbq_mul #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .ctrl_i(mctrl),
    .mc_i  (mc_q),
    .my_i  (my_q),
    .mag_o (mag)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    sec_d   = sec_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_LOAD;
          op_d    = OP_B0;
          sec_d   = '0;
        end
      end
      ST_LOAD: state_d = ST_MLO;
      ST_MLO:  state_d = ST_MHI;
      ST_MHI:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_ACC;
      ST_ACC: begin
        state_d = ST_LOAD;
        case (op_q)
          OP_B0: op_d = OP_B1;
          OP_B1: op_d = OP_A1;
          OP_A1: op_d = OP_B2;
          OP_B2: op_d = OP_A2;
          OP_A2: begin
            if (last_sec) begin
              op_d = OP_GAIN;
            end else begin
              op_d  = OP_B0;
              sec_d = sec_q + SEC_W'(1);
            end
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_B0;
      sec_q       <= '0;
      gain_q      <= GAIN_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SECTIONS; i++) begin
        dly_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      sec_q   <= sec_d;
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_ACC) begin
        case (op_q)
          OP_A1:   dly_q[sec_q].d0 <= acc_sat;
          OP_A2:   dly_q[sec_q].d1 <= acc_sat;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      y_q <= {{(STATE_W-SAMPLE_W-16){in_i.sample_in[SAMPLE_W-1]}}, in_i.sample_in, 16'b0};
    end
    if (state_q == ST_LOAD) begin
      acc_q <= acc_init;
      if (op_q == OP_GAIN) begin
        mc_q  <= {{(COEF_W-GAIN_W){1'b0}}, gain_q};
        neg_q <= opnd[STATE_W-1];
      end else begin
        mc_q  <= cval[COEF_W-1] ? COEF_W'(-cval) : COEF_W'(cval);
        neg_q <= cval[COEF_W-1] ^ opnd[STATE_W-1];
      end
      my_q <= opnd[STATE_W-1] ? OPND_W'(-opnd) : OPND_W'(opnd);
    end
    if (state_q == ST_ACC) begin
      acc_q <= acc_new;
      if (op_q == OP_B0) begin
        yn_q <= acc_sat;
      end
      if (op_q == OP_A2) begin
        y_q <= yn_q;
      end
    end
    if (out_load) begin
      out_sample_q <= in_range ? acc_q[SAMPLE_W-1:0]
                               : (acc_q[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX);
      out_clip_q   <= !in_range;
    end
  end

`ifndef SYNTHESIS
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_LOAD) && (op_q == OP_B0) && (sec_q == '0))
    else $error("sequence did not start at first section");

  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q <= SEC_W'(SECTIONS - 1))
    else $error("section counter out of range");

  a_clip_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_clip_q) |->
      (out_sample_q == SAMPLE_MAX || out_sample_q == SAMPLE_MIN))
    else $error("clip flag without clamped sample");
`endif

endmodule

[tb/sv/cascaded_biquad_equalizer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_biquad_equalizer_tb
// Self-checking bench for the three-section biquad equaliser: a fixed-point
// predictor of the filter cascade, gain and clamp computes each expected
// output sample as its input beat is accepted, and a scoreboard compares every
// output beat against it. Directed samples and gain extremes come first, then
// random phases of noise, rail, square and quiet patterns under random gains,
// with random idling on both streams.
// ----------------------------------------------------------------------------
module cascaded_biquad_equalizer_tb;
  import cbq_pkg::*;

  localparam int unsigned SECTIONS       = 3;
  localparam int unsigned COEF_FRAC_BITS = 22;
  localparam longint      LIMIT_CYCLES   = 4000000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 235;
  localparam int unsigned PRINT_CAP      = 100;
  localparam longint      OUT_HI         = 32767;
  localparam longint      OUT_LO         = -32768;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } eq_result_t;

  typedef enum int {
    PAT_NOISE,
    PAT_QUIET,
    PAT_RAIL,
    PAT_SQUARE
  } pattern_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [GAIN_W-1:0] cfg_wdata_i;

  cbq_in_if  in_bus ();
  cbq_out_if out_bus ();

  cascaded_biquad_equalizer #(
    .SECTIONS      (SECTIONS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  longint            eq_coef [SECTIONS][NUM_COEF];
  longint            eq_delay [2*SECTIONS];
  logic [GAIN_W-1:0] eq_gain;
  eq_result_t        expected_results [$];
  int unsigned       mismatch_count;
  longint            cycle_count;
  int unsigned       stall_left;
  bit                source_idle_en;
  bit                sink_idle_en;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // coefficient rounded half away from zero from 30 fraction bits
  function automatic longint rounded_coef(int unsigned sec, int unsigned k);
    longint      raw;
    longint      m;
    int unsigned sh;
    raw = longint'(COEF_Q30[sec % MAX_SECT][k]);
    sh  = TAB_FRAC - COEF_FRAC_BITS;
    if (sh == 0) begin
      return raw;
    end
    m = (raw < 0) ? -raw : raw;
    m = (m + (longint'(1) << (sh - 1))) >> sh;
    return (raw < 0) ? -m : m;
  endfunction

  // round(c * v / 2^sh) half away from zero, magnitude capped at 2^48
  function automatic longint scaled_product(longint c, longint v, int unsigned sh);
    logic [127:0] full;
    logic [63:0]  mc;
    logic [63:0]  mv;
    mc   = (c < 0) ? -c : c;
    mv   = (v < 0) ? -v : v;
    full = ({64'd0, mc} * {64'd0, mv} + (128'd1 << (sh - 1))) >> sh;
    if (full > (128'd1 << STATE_W)) begin
      full = 128'd1 << STATE_W;
    end
    return ((c < 0) != (v < 0)) ? -longint'(full[63:0]) : longint'(full[63:0]);
  endfunction

  function automatic longint sat_state(longint v);
    if (v > longint'(ST_MAX)) begin
      return longint'(ST_MAX);
    end
    if (v < longint'(ST_MIN)) begin
      return longint'(ST_MIN);
    end
    return v;
  endfunction

  // runs one sample through the cascade, gain and clamp and advances the section delays
  function automatic eq_result_t equalize_sample(logic signed [SAMPLE_W-1:0] s);
    longint     acc;
    longint     yn;
    longint     scaled;
    int         sec;
    eq_result_t r;
    acc = longint'(s) * 65536;
    for (sec = 0; sec < SECTIONS; sec++) begin
      yn = sat_state(scaled_product(eq_coef[sec][K_B0], acc, COEF_FRAC_BITS)
                     + eq_delay[2*sec]);
      eq_delay[2*sec] = sat_state(scaled_product(eq_coef[sec][K_B1], acc, COEF_FRAC_BITS)
                                  - scaled_product(eq_coef[sec][K_A1], yn, COEF_FRAC_BITS)
                                  + eq_delay[2*sec+1]);
      eq_delay[2*sec+1] = sat_state(scaled_product(eq_coef[sec][K_B2], acc, COEF_FRAC_BITS)
                                    - scaled_product(eq_coef[sec][K_A2], yn, COEF_FRAC_BITS));
      acc = yn;
    end
    scaled    = scaled_product(longint'(eq_gain), acc, GAIN_SHIFT);
    r.clipped = 1'b0;
    if (scaled > OUT_HI) begin
      scaled    = OUT_HI;
      r.clipped = 1'b1;
    end else if (scaled < OUT_LO) begin
      scaled    = OUT_LO;
      r.clipped = 1'b1;
    end
    r.sample = scaled[SAMPLE_W-1:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 85) begin
      return $urandom_range(1, 3);
    end
    if (roll < 97) begin
      return $urandom_range(4, 24);
    end
    return $urandom_range(40, 150);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // scoreboard: check output beats, track gain writes, predict accepted beats
  always @(posedge clk_i) begin : scoreboard
    eq_result_t want;
    if (rst_ni) begin
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected beat sample_out %0d clipped %0b",
                                    out_bus.sample_out, out_bus.clipped));
        end else begin
          want = expected_results.pop_front();
          if (out_bus.sample_out !== want.sample) begin
            report_mismatch($sformatf("sample_out %0d, predicted %0d",
                                      out_bus.sample_out, want.sample));
          end
          if (out_bus.clipped !== want.clipped) begin
            report_mismatch($sformatf("clipped %0b, predicted %0b (sample %0d)",
                                      out_bus.clipped, want.clipped, want.sample));
          end
        end
      end
      if (cfg_we_i === 1'b1) begin
        eq_gain = cfg_wdata_i;
      end
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
        expected_results.push_back(equalize_sample(in_bus.sample_in));
      end
    end
  end

  // output back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= pick_gap();
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[cascaded_biquad_equalizer] ERROR");
      $finish;
    end
  end

  // valid stays up across back-to-back beats and is lowered only for a gap or a drain
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    int unsigned gap;
    gap = source_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= value;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic test_default_gain();
    send_sample(16'sd0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    wait_drained();
  endtask

  task automatic test_gain_zero();
    write_gain('0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sd12345);
    wait_drained();
  endtask

  // full-scale gain with rail inputs drives the output into the clamp
  task automatic test_gain_full_scale();
    int i;
    write_gain('1);
    for (i = 0; i < 3; i++) begin
      send_sample(16'sh7fff);
    end
    for (i = 0; i < 3; i++) begin
      send_sample(16'sh8000);
    end
    for (i = 0; i < 6; i++) begin
      send_sample((i % 2 == 0) ? 16'sh7fff : 16'sh8000);
    end
    wait_drained();
  endtask

  task automatic test_gain_lsb();
    write_gain(24'd1);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned sent;
    int unsigned burst;
    int unsigned period;
    int unsigned i;
    int          amp;
    pattern_e    pat;
    logic signed [SAMPLE_W-1:0] value;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0:       write_gain(GAIN_W'($urandom));
        1:       write_gain(GAIN_W'($urandom_range(24'hc00000, 24'hffffff)));
        2:       write_gain(GAIN_W'($urandom_range(24'h100000, 24'h800000)));
        default: write_gain(GAIN_W'($urandom_range(0, 24'h010000)));
      endcase
      // first phase runs flat out on both sides
      source_idle_en = (phase != 0) && ($urandom_range(0, 3) != 0);
      sink_idle_en   = (phase != 0) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pat    = pattern_e'($urandom_range(0, 3));
        burst  = $urandom_range(1, 40);
        amp    = $urandom_range(0, 32767);
        period = $urandom_range(1, 16);
        for (i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
          case (pat)
            PAT_NOISE: value = SAMPLE_W'($urandom);
            PAT_QUIET: value = SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
            PAT_RAIL:  value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default:   value = SAMPLE_W'(((i / period) % 2 == 0) ? amp : -amp - 1);
          endcase
          send_sample(value);
          sent++;
        end
      end
      wait_drained();
    end
  endtask

  initial begin : run
    int sec;
    int k;
    in_bus.valid     = 1'b0;
    in_bus.sample_in = '0;
    out_bus.ready    = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    rst_ni           = 1'b0;
    mismatch_count   = 0;
    cycle_count      = 0;
    stall_left       = 0;
    source_idle_en   = 1'b1;
    sink_idle_en     = 1'b1;
    eq_gain          = GAIN_RESET;
    for (sec = 0; sec < SECTIONS; sec++) begin
      eq_delay[2*sec]   = 0;
      eq_delay[2*sec+1] = 0;
      for (k = 0; k < NUM_COEF; k++) begin
        eq_coef[sec][k] = rounded_coef(sec, k);
      end
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_gain();
    test_gain_zero();
    test_gain_full_scale();
    test_gain_lsb();
    test_random_traffic();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[cascaded_biquad_equalizer] OK");
    end else begin
      $display("[cascaded_biquad_equalizer] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/cbq_pkg.sv
src/cbq_if.sv
src/cbq_mul.sv
src/cascaded_biquad_equalizer.sv
tb/sv/cascaded_biquad_equalizer_tb.sv
